/* rtl/sdc_pkg.sv */
// Shared types and constants for the sorted set difference counter.
`timescale 1ns / 1ps

package sdc_pkg;

    localparam int unsigned FUNC_W = 2;
    localparam int unsigned ELEM_W = 16;
    localparam int unsigned DIFF_W = 10;

    localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

    localparam logic [FUNC_W-1:0] FUNC_APPEND_ONE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND_TWO = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPARE    = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

endpackage

/* rtl/sorted_set_difference_counter_core.sv */
// Top level of the sorted set difference counter.
//
// Usage:
//   A request is taken on a rising edge with start high and busy low. func
//   selects the operation: append element to set one, append element to set
//   two, or compare. Appends never raise busy, so they may come back to
//   back. An append to a full set is dropped and remembered in the overflow
//   flag.
//   A compare raises busy and walks both sets in merged order, one step per
//   cycle, out of two RAMs whose read address is the next walk index. When
//   both sets are exhausted the result shows on difference, no_overlap and
//   overflow with done high for a single cycle, and busy is already low in
//   that cycle. The receiver cannot stall the result.
//   After the compare both sets are empty and the overflow flag is cleared.
//   func 3 is ignored and produces no result.
//   Reset empties both sets, clears the flag and returns to idle; set
//   contents are not cleared, only the fill counts.
`timescale 1ns / 1ps

module sorted_set_difference_counter_core #(
    parameter int unsigned SET_DEPTH = 256,
    parameter int unsigned NODE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [sdc_pkg::FUNC_W-1:0] func,
    input  logic [sdc_pkg::ELEM_W-1:0] element,
    input  logic [sdc_pkg::ELEM_W-1:0] node_one,
    input  logic [sdc_pkg::ELEM_W-1:0] node_two,
    output logic                       done,
    output logic [sdc_pkg::DIFF_W-1:0] difference,
    output logic                       no_overlap,
    output logic                       overflow
);

    // Fill counts must hold SET_DEPTH itself; RAM indexes need only the depth.
    localparam int unsigned CNT_W = $clog2(SET_DEPTH + 1);
    localparam int unsigned IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

    sdc_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt1_reg, cnt1_next;
    logic [CNT_W-1:0] cnt2_reg, cnt2_next;
    logic             drop_reg, drop_next;

    // Walk pointers; i_next/j_next also address the RAM reads.
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;

    logic [sdc_pkg::DIFF_W-1:0] diff_reg, diff_next;
    logic                       ovl_reg, ovl_next;
    logic [NODE_BITS-1:0]       n1_reg, n1_next;
    logic [NODE_BITS-1:0]       n2_reg, n2_next;

    logic                       done_reg, done_next;
    logic [sdc_pkg::DIFF_W-1:0] difference_reg, difference_next;
    logic                       no_overlap_reg, no_overlap_next;
    logic                       overflow_reg, overflow_next;

    logic                 we1, we2;
    logic [NODE_BITS-1:0] elem_w;
    logic [NODE_BITS-1:0] a_data, b_data;
    logic                 a_ok, b_ok;

    assign elem_w = NODE_BITS'(element);

    sdc_set_ram #(
        .DEPTH  (SET_DEPTH),
        .WIDTH  (NODE_BITS),
        .ADDR_W (IDX_W)
    ) u_set_one (
        .clk   (clk),
        .we    (we1),
        .waddr (cnt1_reg[IDX_W-1:0]),
        .wdata (elem_w),
        .raddr (i_next[IDX_W-1:0]),
        .rdata (a_data)
    );

    sdc_set_ram #(
        .DEPTH  (SET_DEPTH),
        .WIDTH  (NODE_BITS),
        .ADDR_W (IDX_W)
    ) u_set_two (
        .clk   (clk),
        .we    (we2),
        .waddr (cnt2_reg[IDX_W-1:0]),
        .wdata (elem_w),
        .raddr (j_next[IDX_W-1:0]),
        .rdata (b_data)
    );

    assign a_ok = (i_reg < cnt1_reg);
    assign b_ok = (j_reg < cnt2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdc_pkg::ST_IDLE;
            cnt1_reg  <= '0;
            cnt2_reg  <= '0;
            drop_reg  <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt1_reg  <= cnt1_next;
            cnt2_reg  <= cnt2_next;
            drop_reg  <= drop_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            done_reg  <= done_next;
        end
    end

    // Walk and result payload, no reset needed.
    always_ff @(posedge clk)
    begin
        diff_reg       <= diff_next;
        ovl_reg        <= ovl_next;
        n1_reg         <= n1_next;
        n2_reg         <= n2_next;
        difference_reg <= difference_next;
        no_overlap_reg <= no_overlap_next;
        overflow_reg   <= overflow_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt1_next       = cnt1_reg;
        cnt2_next       = cnt2_reg;
        drop_next       = drop_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        diff_next       = diff_reg;
        ovl_next        = ovl_reg;
        n1_next         = n1_reg;
        n2_next         = n2_reg;
        done_next       = 1'b0;
        difference_next = difference_reg;
        no_overlap_next = no_overlap_reg;
        overflow_next   = overflow_reg;
        we1             = 1'b0;
        we2             = 1'b0;

        unique case (state_reg)
            sdc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (func)
                        sdc_pkg::FUNC_APPEND_ONE:
                        begin
                            if (cnt1_reg < CNT_W'(SET_DEPTH))
                            begin
                                we1       = 1'b1;
                                cnt1_next = cnt1_reg + CNT_W'(1);
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        sdc_pkg::FUNC_APPEND_TWO:
                        begin
                            if (cnt2_reg < CNT_W'(SET_DEPTH))
                            begin
                                we2       = 1'b1;
                                cnt2_next = cnt2_reg + CNT_W'(1);
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        sdc_pkg::FUNC_COMPARE:
                        begin
                            i_next     = '0;
                            j_next     = '0;
                            diff_next  = '0;
                            ovl_next   = 1'b0;
                            n1_next    = NODE_BITS'(node_one);
                            n2_next    = NODE_BITS'(node_two);
                            state_next = sdc_pkg::ST_WALK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            sdc_pkg::ST_WALK:
            begin
                // a_data/b_data hold entries i_reg/j_reg this cycle.
                if (a_ok && b_ok)
                begin
                    if (a_data == n2_reg)
                    begin
                        ovl_next = 1'b1;
                        i_next   = i_reg + CNT_W'(1);
                    end
                    else if (b_data == n1_reg)
                    begin
                        ovl_next = 1'b1;
                        j_next   = j_reg + CNT_W'(1);
                    end
                    else if (a_data < b_data)
                    begin
                        i_next = i_reg + CNT_W'(1);
                        if (diff_reg != sdc_pkg::DIFF_MAX)
                        begin
                            diff_next = diff_reg + sdc_pkg::DIFF_W'(1);
                        end
                    end
                    else if (a_data > b_data)
                    begin
                        j_next = j_reg + CNT_W'(1);
                        if (diff_reg != sdc_pkg::DIFF_MAX)
                        begin
                            diff_next = diff_reg + sdc_pkg::DIFF_W'(1);
                        end
                    end
                    else
                    begin
                        ovl_next = 1'b1;
                        i_next   = i_reg + CNT_W'(1);
                        j_next   = j_reg + CNT_W'(1);
                    end
                end
                else if (a_ok)
                begin
                    i_next = i_reg + CNT_W'(1);
                    if (a_data == n2_reg)
                    begin
                        ovl_next = 1'b1;
                    end
                    else if (diff_reg != sdc_pkg::DIFF_MAX)
                    begin
                        diff_next = diff_reg + sdc_pkg::DIFF_W'(1);
                    end
                end
                else if (b_ok)
                begin
                    j_next = j_reg + CNT_W'(1);
                    if (b_data == n1_reg)
                    begin
                        ovl_next = 1'b1;
                    end
                    else if (diff_reg != sdc_pkg::DIFF_MAX)
                    begin
                        diff_next = diff_reg + sdc_pkg::DIFF_W'(1);
                    end
                end
                else
                begin
                    // Both sets exhausted: emit and empty the sets.
                    difference_next = diff_reg;
                    no_overlap_next = !ovl_reg;
                    overflow_next   = drop_reg;
                    done_next       = 1'b1;
                    cnt1_next       = '0;
                    cnt2_next       = '0;
                    drop_next       = 1'b0;
                    state_next      = sdc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sdc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != sdc_pkg::ST_IDLE);
    assign done       = done_reg;
    assign difference = difference_reg;
    assign no_overlap = no_overlap_reg;
    assign overflow   = overflow_reg;

endmodule

/* rtl/sdc_set_ram.sv */
// Single-port-write, registered-read RAM holding one neighbor set.
`timescale 1ns / 1ps

module sdc_set_ram #(
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned WIDTH  = 16,
    parameter int unsigned ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
